// ===== hw/rtl/symbol_palette_pixel_decoder_macros.svh =====
// Assertion macros shared by the symbol palette pixel decoder RTL
`ifndef SYMBOL_PALETTE_PIXEL_DECODER_MACROS_SVH
`define SYMBOL_PALETTE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset
`define SPPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset
`define SPPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sppd_pkg.sv =====
// Shared types and constants of the symbol palette pixel decoder
`timescale 1ns / 1ps

package sppd_pkg;

  // Palette storage
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = 8;
  localparam int CNT_W       = 9;
  localparam int MAX_CHARS   = 7;
  localparam int SYM_W       = 8 * MAX_CHARS;

  // Item kinds carried in tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHARS_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_PALETTE_SIZE    = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_FORMAT   = 2'd2;

  // Output format codes
  localparam logic [2:0] FMT_RGBA32 = 3'd0;
  localparam logic [2:0] FMT_INDEX8 = 3'd1;
  localparam logic [2:0] FMT_INDEX4 = 3'd2;
  localparam logic [2:0] FMT_INDEX2 = 3'd3;
  localparam logic [2:0] FMT_INDEX1 = 3'd4;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // Search outcome handed to the formatter
  typedef struct packed {
    logic        step;
    logic        found;
    logic        eoi;
    logic [2:0]  fmt;
    logic [7:0]  hit;
    logic [31:0] color;
  } fmt_req_t;

  // Formatter answer
  typedef struct packed {
    logic        emit;
    logic        status;
    logic [31:0] data;
  } fmt_rsp_t;

endpackage

// ===== hw/rtl/sppd_format.sv =====
// Result formatter: RGBA, index8 and packed index bytes with packing state
`timescale 1ns / 1ps

module sppd_format
  import sppd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  fmt_req_t req,
  output fmt_rsp_t rsp
);

  logic [7:0] pack_byte;
  logic [7:0] pack_byte_next;
  logic [2:0] pack_position;
  logic [2:0] pack_position_next;

  logic [3:0] bits;
  logic [2:0] pos_mask;
  logic [7:0] vmask;
  logic [2:0] pos;
  logic [7:0] prod;
  logic [3:0] shift;
  logic [7:0] merged;
  logic       full;

  // Select slot geometry for the packed formats
  always_comb begin
    unique case (req.fmt)
      FMT_INDEX4: begin
        bits     = 4'd4;
        pos_mask = 3'b001;
        vmask    = 8'h0F;
      end
      FMT_INDEX2: begin
        bits     = 4'd2;
        pos_mask = 3'b011;
        vmask    = 8'h03;
      end
      default: begin
        bits     = 4'd1;
        pos_mask = 3'b111;
        vmask    = 8'h01;
      end
    endcase
  end

  // Place the index into its slot, first pixel in the high bits
  always_comb begin
    pos    = pack_position & pos_mask;
    prod   = 8'(bits * (4'({1'b0, pos}) + 4'd1));
    shift  = 4'd8 - prod[3:0];
    merged = (pack_byte & ~(vmask << shift)) | ((req.hit & vmask) << shift);
    full   = (pos == pos_mask);
  end

  // Build the result and the next packing state
  always_comb begin
    rsp                = '0;
    pack_byte_next     = pack_byte;
    pack_position_next = pack_position;
    if (!req.found) begin
      rsp.emit           = 1'b1;
      rsp.status         = STATUS_UNKNOWN;
      pack_byte_next     = '0;
      pack_position_next = '0;
    end else begin
      unique case (req.fmt)
        FMT_RGBA32: begin
          rsp.emit = 1'b1;
          rsp.data = req.color;
        end
        FMT_INDEX8: begin
          rsp.emit = 1'b1;
          rsp.data = {24'd0, req.hit};
        end
        FMT_INDEX4, FMT_INDEX2, FMT_INDEX1: begin
          if (full || req.eoi) begin
            rsp.emit           = 1'b1;
            rsp.data           = {24'd0, merged};
            pack_byte_next     = '0;
            pack_position_next = '0;
          end else begin
            pack_byte_next     = merged;
            pack_position_next = pos + 3'd1;
          end
        end
        default: begin
          rsp.emit = 1'b0;
        end
      endcase
    end
    rsp.status = rsp.status & rsp.emit;
  end

  // Commit packing state when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_byte     <= '0;
      pack_position <= '0;
    end else if (req.step) begin
      pack_byte     <= pack_byte_next;
      pack_position <= pack_position_next;
    end
  end

endmodule

// ===== hw/rtl/symbol_palette_pixel_decoder.sv =====
// Channel        | Direction | Content
// s_axis         | in        | tdata: entry_index, symbol, red, green, blue, alpha;
//                |           | tuser: mode; tlast: end_of_image
// m_axis         | out       | tdata: out_data; tuser: status
// cfg            | in        | cfg_index, cfg_data register writes, always ready
//
// A load item writes its palette entry when accepted. A decode item scans palette
// entries through the key memory's registered read port, one entry per cycle. The
// scan stops at the first matching entry, or on a miss once the searched size
// (palette_size clamped to the depth) has been read, and the input is freed after
// the result moves on. rst is synchronous; palette memories are not cleared. The
// input stalls while a search runs or while a result cannot enter the output
// register; the output register holds a result until taken.
`timescale 1ns / 1ps
`include "symbol_palette_pixel_decoder_macros.svh"

module symbol_palette_pixel_decoder
  import sppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // entry_index 7:0, symbol 63:8, red 71:64, green 79:72, blue 87:80, alpha 95:88
  input  logic [95:0] s_axis_tdata,
  // mode
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // out_data 31:0
  output logic [31:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [2:0] chars_per_pixel;
  logic [8:0] palette_size;
  logic [2:0] output_format;

  logic [SYM_W-1:0] key_mem [PAL_ENTRIES];
  logic [31:0]      color_mem [PAL_ENTRIES];
  logic [SYM_W-1:0] key_q;
  logic [31:0]      color_q;

  logic [SYM_W-1:0]  sym;
  logic              eoi;
  logic [CNT_W-1:0]  issue_cnt;
  logic [CNT_W-1:0]  limit;
  logic              cmp_valid;
  logic [PAL_AW-1:0] cmp_idx;
  logic              res_found;
  logic [PAL_AW-1:0] res_hit;
  logic [31:0]       res_color;

  logic in_fire;
  logic mem_we;
  logic rd_en;
  logic key_match;
  logic search_hit;
  logic search_miss;
  logic out_free;
  logic step;

  fmt_req_t fmt_req;
  fmt_rsp_t fmt_rsp;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_pixel <= 3'd1;
      palette_size    <= 9'd2;
      output_format   <= FMT_RGBA32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHARS_PER_PIXEL: chars_per_pixel <= cfg_data[2:0];
        CFG_PALETTE_SIZE:    palette_size    <= cfg_data;
        CFG_OUTPUT_FORMAT:   output_format   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the scan length to the palette depth
  assign limit = (palette_size > CNT_W'(PAL_ENTRIES)) ? CNT_W'(PAL_ENTRIES)
                                                      : palette_size;

  // Compare the enabled leading characters of the fetched key
  always_comb begin
    key_match = 1'b1;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if ((i < int'(chars_per_pixel)) && (key_q[8*i +: 8] != sym[8*i +: 8])) begin
        key_match = 1'b0;
      end
    end
  end

  assign search_hit  = (state == ST_SEARCH) && cmp_valid && key_match;
  assign search_miss = (state == ST_SEARCH) && !cmp_valid && (issue_cnt >= limit);

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser == MODE_DECODE)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_hit || search_miss) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive sequencer controls
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    step          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_we        = s_axis_tvalid && (s_axis_tuser == MODE_LOAD);
      end
      ST_SEARCH: begin
        rd_en = (issue_cnt < limit);
      end
      ST_RESULT: begin
        step = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store palette entries as r, g, b, a from the high byte down; fetch one entry per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[s_axis_tdata[7:0]]   <= s_axis_tdata[63:8];
      color_mem[s_axis_tdata[7:0]] <= {s_axis_tdata[71:64], s_axis_tdata[79:72],
                                       s_axis_tdata[87:80], s_axis_tdata[95:88]};
    end
    if (rd_en) begin
      key_q   <= key_mem[issue_cnt[PAL_AW-1:0]];
      color_q <= color_mem[issue_cnt[PAL_AW-1:0]];
    end
  end

  // Track the scan position and the compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (in_fire) begin
        issue_cnt <= '0;
      end else if (rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  // Capture the item and the search outcome
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx <= issue_cnt[PAL_AW-1:0];
    end
    if (in_fire) begin
      sym <= s_axis_tdata[63:8];
      eoi <= s_axis_tlast;
    end
    if (search_hit) begin
      res_found <= 1'b1;
      res_hit   <= cmp_idx;
      res_color <= color_q;
    end else if (search_miss) begin
      res_found <= 1'b0;
    end
  end

  assign fmt_req = '{
    step:  step,
    found: res_found,
    eoi:   eoi,
    fmt:   output_format,
    hit:   res_hit,
    color: res_color
  };

  sppd_format u_format (
    .clk (clk),
    .rst (rst),
    .req (fmt_req),
    .rsp (fmt_rsp)
  );

  // Hold the result until the downstream side takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && fmt_rsp.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && fmt_rsp.emit) begin
      m_axis_tdata <= fmt_rsp.data;
      m_axis_tuser <= fmt_rsp.status;
    end
  end

  `SPPD_ASSERT_NEXT(a_decode_starts_search, in_fire && (s_axis_tuser == MODE_DECODE), state == ST_SEARCH, "decode item did not start a search")
  `SPPD_ASSERT_NEXT(a_hit_ends_search, search_hit, (state == ST_RESULT) && res_found && (res_hit == $past(cmp_idx)), "match not captured")
  `SPPD_ASSERT_NOW(a_scan_bounded, state == ST_SEARCH, issue_cnt <= limit, "scan ran past the palette size")
  `SPPD_ASSERT_NOW(a_miss_reports, step && !res_found, fmt_rsp.emit && (fmt_rsp.status == STATUS_UNKNOWN) && (fmt_rsp.data == 32'd0), "unknown symbol gave no error result")

endmodule
